/* rtl/mm3_pkg.sv */
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants, queue entry type and back-end state codes for the
// MurmurHash3 x86_32 byte stream core.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] CN = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  // One queue entry: work the back end does for one beat.
  typedef struct packed {
    logic        empty;   // zero-length key: finalize seed alone
    logic        first;   // first work of a key: load hash from seed
    logic        mix;     // full block in word, full round
    logic        fin;     // finalize after this work
    logic        tail;    // partial tail in word, xor in scrambled
    logic [31:0] seed;
    logic [31:0] word;
    logic [31:0] len;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_MIX,
    S_LEN,
    S_FIN,
    S_F2,
    S_OUT
  } back_state_t;

endpackage

/* rtl/murmur3_32_byte_stream_hash_core.sv */
// ----------------------------------------------------------------------------
// murmur3_32_byte_stream_hash_core
// MurmurHash3 x86_32 over a key streamed one byte per beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): data_byte, last_byte, empty_key. A beat
// with last_byte set ends the key; a beat with empty_key set hashes an empty
// key and drops any key in progress. Output channel (out_valid/out_ready)
// carries one hash_value per finished key. cfg_we/cfg_data load the seed,
// taken at the first byte of the next key (or at an empty-key beat).
// The front packs bytes and queues one entry per full block or key end in a
// two-entry queue; the back end sequences the multiplies, one per cycle.
// Within a key the front takes one byte per cycle while in_ready is high;
// a full block costs the back end a pop, two scramble multiplies and a mix,
// so blocks keep up with bytes. A key end adds the length xor, the finalize
// multiplies and the output step (no scramble or mix for an empty key), which
// sets the rate for short keys. A key-end entry waits behind queued work,
// steps S_K1 to S_F2 (an empty key from S_LEN) and S_OUT raises out_valid.
// Reset clears the seed to zero and drops any key in progress.
// When the receiver stalls the result holds in the output register; the back
// end then waits and the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module murmur3_32_byte_stream_hash_core import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  logic [31:0] seed;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_data;
    end
  end

  mm3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .empty_key (empty_key),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  mm3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .full      (q_full),
    .not_empty (q_valid)
  );

  mm3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

/* rtl/mm3_front.sv */
// ----------------------------------------------------------------------------
// mm3_front
// Accepts key bytes, packs them little-endian into blocks, counts length and
// issues one queue entry per full block, key end or empty key.
// ----------------------------------------------------------------------------
module mm3_front import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_key,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        q_full
);

  logic        in_key;
  logic        blk_sent;
  logic [1:0]  phase;
  logic [23:0] partial;
  logic [31:0] length;
  logic [31:0] seed_lat;

  logic        accept;
  logic        first;
  logic        blk;
  logic [23:0] part_ins;
  logic [31:0] len_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign first    = !in_key;
  assign blk      = (phase == 2'd3);
  assign len_new  = length + 32'd1;

  always_comb begin
    case (phase)
      2'd0:    part_ins = {16'd0, data_byte};
      2'd1:    part_ins = {8'd0, data_byte, partial[7:0]};
      2'd2:    part_ins = {data_byte, partial[15:0]};
      default: part_ins = partial;
    endcase
  end

  always_comb begin
    push_cmd = '0;
    if (empty_key) begin
      push_cmd.empty = 1'b1;
      push_cmd.seed  = seed;
      push           = accept;
    end else begin
      // first entry of the key loads the hash, even when earlier bytes
      // of the key pushed nothing
      push_cmd.first = !blk_sent;
      push_cmd.seed  = first ? seed : seed_lat;
      push_cmd.mix   = blk;
      push_cmd.fin   = last_byte;
      push_cmd.tail  = last_byte && !blk;
      push_cmd.word  = blk ? {data_byte, partial} : {8'd0, part_ins};
      push_cmd.len   = len_new;
      push           = accept && (blk || last_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_key   <= 1'b0;
      blk_sent <= 1'b0;
      phase    <= 2'd0;
      partial  <= '0;
      length   <= '0;
    end else if (accept) begin
      if (empty_key || last_byte) begin
        in_key   <= 1'b0;
        blk_sent <= 1'b0;
        phase    <= 2'd0;
        partial  <= '0;
        length   <= '0;
      end else begin
        in_key  <= 1'b1;
        if (blk) begin
          blk_sent <= 1'b1;
        end
        phase   <= phase + 2'd1;
        partial <= blk ? 24'd0 : part_ins;
        length  <= len_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !empty_key && first) begin
      seed_lat <= seed;
    end
  end

endmodule

/* rtl/mm3_queue.sv */
// ----------------------------------------------------------------------------
// mm3_queue
// Two-entry queue of work entries between front and back end.
// ----------------------------------------------------------------------------
module mm3_queue import mm3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic not_empty
);

  cmd_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_cmd   = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/mm3_back.sv */
// ----------------------------------------------------------------------------
// mm3_back
// Sequencer that scrambles blocks, mixes the running hash, and finalizes.
// One multiply per cycle, registered before the next step.
// ----------------------------------------------------------------------------
module mm3_back import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);

  back_state_t state, state_next;
  cmd_t        cur;
  logic [31:0] h;
  logic [31:0] k;
  logic [31:0] hk;
  logic [31:0] hr;
  logic        out_free;

  assign out_free = !out_valid || out_ready;
  assign hk       = h ^ k;
  assign hr       = {hk[18:0], hk[31:19]};

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_cmd.empty) begin
            state_next = S_LEN;
          end else if (q_cmd.mix || q_cmd.tail) begin
            state_next = S_K1;
          end else begin
            state_next = S_LEN;
          end
        end
      end
      S_K1:  state_next = S_K2;
      S_K2:  state_next = S_MIX;
      S_MIX: state_next = cur.fin ? S_LEN : S_IDLE;
      S_LEN: state_next = S_FIN;
      S_FIN: state_next = S_F2;
      S_F2:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur <= q_cmd;
          if (q_cmd.empty || q_cmd.first) begin
            h <= q_cmd.seed;
          end
        end
      end
      S_K1: k <= cur.word * C1;
      S_K2: k <= {k[16:0], k[31:17]} * C2;
      S_MIX: begin
        if (cur.mix) begin
          h <= {hr[29:0], 2'b00} + hr + CN;
        end else begin
          h <= hk;
        end
      end
      S_LEN: h <= h ^ cur.len;
      S_FIN: h <= (h ^ {16'd0, h[31:16]}) * F1;
      S_F2:  h <= (h ^ {13'd0, h[31:13]}) * F2;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      hash_value <= h ^ {16'd0, h[31:16]};
    end
  end

endmodule

/* verif/murmur3_32_byte_stream_hash_core_tb.sv */
// ----------------------------------------------------------------------------
// murmur3_32_byte_stream_hash_core_tb
// Streams keys one byte per beat into the core, with random gaps on both
// channels, and checks every hash against a behavioral MurmurHash3 x86_32
// model kept in the bench. Covers empty keys, aborted keys, all tail sizes,
// seed extremes, seed changes inside a key and output back-pressure.
// ----------------------------------------------------------------------------
module murmur3_32_byte_stream_hash_core_tb import mm3_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 40;    // covers back-end latency plus queued blocks
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 40;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        empty_key = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] hash_value;

  murmur3_32_byte_stream_hash_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .empty_key  (empty_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  // bench copy of the hash state
  logic [31:0] seed_now   = '0;
  logic [31:0] run_hash   = '0;
  logic [31:0] tail_word  = '0;
  logic [31:0] byte_count = '0;
  logic [1:0]  fill       = '0;
  bit          key_open   = 1'b0;

  logic [31:0] hash_q[$];
  int          n_errs   = 0;
  int          n_cycles = 0;
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * C1;
    t = rotl32(t, 15);
    return t * C2;
  endfunction

  function automatic logic [31:0] fmix32(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * F1;
    t = t ^ (t >> 13);
    t = t * F2;
    return t ^ (t >> 16);
  endfunction

  task automatic clear_key_state();
    run_hash   = '0;
    tail_word  = '0;
    byte_count = '0;
    fill       = '0;
    key_open   = 1'b0;
  endtask

  // advance the bench hash by one accepted beat, queue the hash it yields
  task automatic absorb_beat(input logic [7:0] b, input logic l, input logic e);
    logic [31:0] h;
    if (e) begin
      clear_key_state();
      hash_q.push_back(fmix32(seed_now));
    end else begin
      if (!key_open) begin
        clear_key_state();
        run_hash = seed_now;
        key_open = 1'b1;
      end
      if (fill == 2'd3) begin
        run_hash  = rotl32(run_hash ^ scramble_block(tail_word | {b, 24'h0}), 13);
        run_hash  = run_hash * 5 + CN;
        tail_word = '0;
        fill      = '0;
      end else begin
        tail_word = tail_word | ({24'h0, b} << (8 * fill));
        fill      = fill + 2'd1;
      end
      byte_count = byte_count + 32'd1;
      if (l) begin
        h = run_hash;
        if (fill != 2'd0) h = h ^ scramble_block(tail_word);
        h = h ^ byte_count;
        hash_q.push_back(fmix32(h));
        clear_key_state();
      end
    end
  endtask

  task automatic flag_mismatch(input string what);
    if (n_errs < MAX_SHOWN) $display("MISMATCH @%0d: %s", n_cycles, what);
    n_errs++;
  endtask

  task automatic send_beat(input logic [7:0] b, input logic l, input logic e);
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    empty_key <= e;
    do @(posedge clk); while (!in_ready);
    absorb_beat(b, l, e);
  endtask

  // sender stops until every queued hash has come out and the back end is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_seed(input logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    seed_now = v;
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_keys();
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_tail_sizes();
    logic [7:0] pat[15];
    int         k;
    pat = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h7f, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff,
            8'h00, 8'h11, 8'h22, 8'h33, 8'hff};
    k = 0;
    // keys of length 1 through 5
    for (int len = 1; len <= 5; len++) begin
      for (int i = 1; i <= len; i++) begin
        send_beat(pat[k], i == len, 1'b0);
        k++;
      end
    end
  endtask

  task automatic test_abort_mid_key();
    settle();
    load_seed(32'hffff_ffff);
    send_beat(8'ha5, 1'b0, 1'b0);
    send_beat(8'h3c, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b0);
  endtask

  task automatic test_seed_change_mid_key();
    send_beat(8'hc3, 1'b0, 1'b0);
    settle();
    load_seed(32'h8000_0000);
    send_beat(8'h81, 1'b0, 1'b0);
    send_beat(8'h7e, 1'b1, 1'b0);
  endtask

  // mostly whole keys with random bytes; some stray empty beats and cut keys
  task automatic run_random_keys(input int unsigned n_items, input bit leave_open);
    int unsigned sent, len, cut, r;
    bit          broken;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
        sent++;
      end else begin
        len    = (r < 90) ? $urandom_range(1, 12) : $urandom_range(13, 64);
        broken = $urandom_range(99) < 5;
        cut    = $urandom_range(1, len);
        for (int unsigned i = 1; i <= len; i++) begin
          if (broken && i == cut) begin
            send_beat(8'($urandom), 1'($urandom_range(1)), 1'b1);
            sent++;
            break;
          end
          send_beat(8'($urandom), i == len, 1'b0);
          sent++;
        end
      end
    end
    if (leave_open) begin
      for (int i = 0; i < 3; i++) send_beat(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    settle();
    load_seed(32'h0000_0001);
    run_random_keys(200, 1'b0);
    settle();
    load_seed($urandom);
    quiet = 1'b1;
    run_random_keys(200, 1'b0);
    quiet = 1'b0;
    settle();
    load_seed(32'h0000_0000);
    hold_req = 1'b1;
    run_random_keys(200, 1'b0);
    settle();
    load_seed(32'hffff_ffff);
    run_random_keys(200, 1'b1);
    // key left open above finishes under the seed it started with, not the new one
    settle();
    load_seed($urandom);
    run_random_keys(200, 1'b0);
  endtask

  // receiver: random stalls, a no-stall stretch, one long hold-off
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && out_ready) begin
      if (hash_q.size() == 0) begin
        flag_mismatch($sformatf("hash %08h with none expected", hash_value));
      end else begin
        want = hash_q.pop_front();
        if (hash_value !== want)
          flag_mismatch($sformatf("hash_value %08h, want %08h", hash_value, want));
      end
    end
  end

  initial begin
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("murmur3_32_byte_stream_hash_core_tb: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_keys();
    test_tail_sizes();
    test_abort_mid_key();
    test_seed_change_mid_key();
    test_random_traffic();
    settle();
    if (n_errs == 0) begin
      $display("murmur3_32_byte_stream_hash_core_tb: clean");
    end else begin
      $display("murmur3_32_byte_stream_hash_core_tb: errors");
    end
    $finish;
  end

endmodule
